[rtl/stx_etx_dle_deframer_assert.svh]
// Assertion macros used by the deframer RTL.
// Define NO_ASSERTIONS to compile the design without them.
`ifndef STX_ETX_DLE_DEFRAMER_ASSERT_SVH
`define STX_ETX_DLE_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SEDD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed (same cycle)");

`define SEDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed (next cycle)");

`else

`define SEDD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define SEDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/sedd_pkg.sv]
`timescale 1ns / 1ps

package sedd_pkg;

    localparam int LEN_W = 13;
    localparam int CNT_W = 32;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DLE = 8'h10;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd256;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RECV = 2'd1,
        MODE_ESC  = 2'd2
    } t_rx_mode;

    typedef enum logic [2:0] {
        EV_DATA  = 3'd0,
        EV_END   = 3'd1,
        EV_EMPTY = 3'd2,
        EV_STX   = 3'd3,
        EV_OVF   = 3'd4
    } t_event;

    typedef struct packed {
        t_event             kind;
        logic [7:0]         data;
        logic [LEN_W-1:0]   len;
        logic [CNT_W-1:0]   good;
        logic [CNT_W-1:0]   err;
    } t_result;

endpackage

[rtl/sedd_fsm.sv]
`timescale 1ns / 1ps

`include "stx_etx_dle_deframer_assert.svh"

module sedd_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [7:0]                  i_byte,
    input  logic [sedd_pkg::LEN_W-1:0]  i_max_len,
    output logic                        o_res_valid,
    output sedd_pkg::t_result           o_res
);

    sedd_pkg::t_rx_mode           r_mode, n_mode;
    logic [sedd_pkg::LEN_W-1:0]   r_slot, n_slot;
    logic [sedd_pkg::LEN_W-1:0]   r_payload, n_payload;
    logic [sedd_pkg::CNT_W-1:0]   r_good, n_good;
    logic [sedd_pkg::CNT_W-1:0]   r_err, n_err;
    logic [sedd_pkg::LEN_W:0]     esc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= sedd_pkg::MODE_IDLE;
            r_slot    <= '0;
            r_payload <= '0;
            r_good    <= '0;
            r_err     <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_slot    <= n_slot;
            r_payload <= n_payload;
            r_good    <= n_good;
            r_err     <= n_err;
        end
    end

    assign esc_sum = {1'b0, r_slot} + (sedd_pkg::LEN_W+1)'(2);

    always_comb begin
        n_mode      = r_mode;
        n_slot      = r_slot;
        n_payload   = r_payload;
        n_good      = r_good;
        n_err       = r_err;
        o_res_valid = 1'b0;
        o_res.kind  = sedd_pkg::EV_DATA;
        o_res.data  = 8'h00;
        o_res.len   = '0;
        case (r_mode)
            sedd_pkg::MODE_RECV: begin
                if (i_byte == sedd_pkg::CH_ETX) begin
                    n_mode      = sedd_pkg::MODE_IDLE;
                    o_res_valid = 1'b1;
                    if (r_payload != '0) begin
                        n_good     = r_good + 32'd1;
                        o_res.kind = sedd_pkg::EV_END;
                        o_res.len  = r_payload;
                    end else begin
                        n_err      = r_err + 32'd1;
                        o_res.kind = sedd_pkg::EV_EMPTY;
                    end
                end else if (i_byte == sedd_pkg::CH_DLE) begin
                    n_mode = sedd_pkg::MODE_ESC;
                end else if (i_byte == sedd_pkg::CH_STX) begin
                    n_slot      = '0;
                    n_payload   = '0;
                    n_err       = r_err + 32'd1;
                    o_res_valid = 1'b1;
                    o_res.kind  = sedd_pkg::EV_STX;
                end else if (r_slot < i_max_len) begin
                    n_slot      = r_slot + 13'd1;
                    n_payload   = r_payload + 13'd1;
                    o_res_valid = 1'b1;
                    o_res.data  = i_byte;
                end else begin
                    n_mode      = sedd_pkg::MODE_IDLE;
                    n_err       = r_err + 32'd1;
                    o_res_valid = 1'b1;
                    o_res.kind  = sedd_pkg::EV_OVF;
                end
            end
            sedd_pkg::MODE_ESC: begin
                o_res_valid = 1'b1;
                if (esc_sum <= {1'b0, i_max_len}) begin
                    n_slot     = esc_sum[sedd_pkg::LEN_W-1:0];
                    n_payload  = r_payload + 13'd1;
                    n_mode     = sedd_pkg::MODE_RECV;
                    o_res.data = i_byte;
                end else begin
                    n_mode     = sedd_pkg::MODE_IDLE;
                    n_err      = r_err + 32'd1;
                    o_res.kind = sedd_pkg::EV_OVF;
                end
            end
            default: begin
                n_mode = sedd_pkg::MODE_IDLE;
                if (i_byte == sedd_pkg::CH_STX) begin
                    n_mode    = sedd_pkg::MODE_RECV;
                    n_slot    = '0;
                    n_payload = '0;
                end
            end
        endcase
        o_res.good = n_good;
        o_res.err  = n_err;
    end

    `SEDD_ASSERT_SAME(a_payload_le_slot, i_clk, i_rst_n, 1'b1, r_payload <= r_slot)
    `SEDD_ASSERT_NEXT(a_ovf_goes_idle, i_clk, i_rst_n, i_fire && o_res_valid && o_res.kind == sedd_pkg::EV_OVF, r_mode == sedd_pkg::MODE_IDLE)
    `SEDD_ASSERT_NEXT(a_err_counts_errors, i_clk, i_rst_n, i_fire && o_res_valid && (o_res.kind == sedd_pkg::EV_EMPTY || o_res.kind == sedd_pkg::EV_STX || o_res.kind == sedd_pkg::EV_OVF), r_err == $past(r_err) + 32'd1)
    `SEDD_ASSERT_NEXT(a_good_only_on_end, i_clk, i_rst_n, !(i_fire && o_res_valid && o_res.kind == sedd_pkg::EV_END), r_good == $past(r_good))

endmodule

[rtl/stx_etx_dle_deframer.sv]
`timescale 1ns / 1ps

// STX/ETX/DLE deframer. Raw line bytes enter one per transfer; each unescaped
// payload byte leaves as its own result, and frame end, empty frame, restart on
// a stray STX and overflow are reported as events together with the running
// good and error frame counts. The block takes one byte every clock cycle while
// the output is not stalled. A byte is held in the input register, and its
// result is registered in the output register before it is presented. The
// rate is set by the per-byte update of the receive mode and slot counts. A
// stalled result holds the byte behind it, so the input stalls only while both
// registers are full. Bytes that cause no event still pass through the input
// register. The user must write the slot limit only while no byte is in flight;
// the block itself does not enforce this.
module stx_etx_dle_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_data_byte,
    output logic [12:0] o_frame_length,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_error_frames
);

    logic [sedd_pkg::LEN_W-1:0] r_max_len;
    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_out_valid;
    sedd_pkg::t_result          r_out;
    sedd_pkg::t_result          res;
    logic                       res_valid;
    logic                       advance;
    logic                       fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= sedd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_byte_in;
        end
    end

    sedd_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out.kind;
    assign o_data_byte    = r_out.data;
    assign o_frame_length = r_out.len;
    assign o_good_frames  = r_out.good;
    assign o_error_frames = r_out.err;

endmodule
